// ===== rtl/cyf_pkg.sv =====
//------------------------------------------------------------------------------
// cyf_pkg
// Shared types and constants of the complementary yaw filter.
//------------------------------------------------------------------------------
package cyf_pkg;

    localparam int TAB_LEN = 30;
    localparam logic [31:0] GYRO_MUL = 32'd716770142;
    localparam logic [31:0] CORDIC_X0 = 32'd652032874;
    localparam logic [19:0] DT_MAX = 20'hFFFFF;
    localparam logic [19:0] DT_FALLBACK = 20'd1000;
    localparam logic [16:0] ALPHA_RESET = 17'd64225;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic [0:0] REG_ALPHA = 1'b0;

    typedef logic [31:0] t_atan_tab [TAB_LEN];
    localparam t_atan_tab ATAN_TAB = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
        32'd2670163, 32'd1335087, 32'd667544, 32'd333772, 32'd166886,
        32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215, 32'd2608,
        32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20,
        32'd10, 32'd5, 32'd3, 32'd1};

    // request to the shared CORDIC
    typedef struct packed {
        logic        start;
        logic        vectoring;
        logic [35:0] x0;
        logic [35:0] y0;
        logic [32:0] z0;
    } t_cordic_req;

    typedef struct packed {
        logic        done;
        logic [35:0] x;
        logic [35:0] y;
        logic [32:0] z;
    } t_cordic_rsp;

endpackage

// ===== rtl/cyf_if.sv =====
//------------------------------------------------------------------------------
// cyf_in_if / cyf_out_if
// Valid/ready channels of the complementary yaw filter.
//------------------------------------------------------------------------------
interface cyf_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] timestamp_us;
    logic signed [17:0] gyro_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, timestamp_us, gyro_z, quat_x, quat_y, quat_z, quat_w,
                    input ready);
    modport sink (input valid, timestamp_us, gyro_z, quat_x, quat_y, quat_z, quat_w,
                  output ready);
endinterface

interface cyf_out_if;
    logic        valid;
    logic        ready;
    logic signed [17:0] yaw_angle;
    logic signed [15:0] out_z;
    logic [14:0] out_w;
    logic [47:0] out_time_us;
    modport source (output valid, yaw_angle, out_z, out_w, out_time_us, input ready);
    modport sink (input valid, yaw_angle, out_z, out_w, out_time_us, output ready);
endinterface

// ===== rtl/cyf_cordic.sv =====
//------------------------------------------------------------------------------
// cyf_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
//------------------------------------------------------------------------------
module cyf_cordic import cyf_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);
    localparam int NS = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
    localparam int CW = $clog2(NS + 1);

    logic              r_busy, r_vec, r_done;
    logic [CW-1:0]     r_cnt;
    logic signed [35:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic signed [35:0] w_dx, w_dy;
    logic signed [32:0] w_at;
    logic               w_up;

    assign w_dx = r_y >>> r_cnt;
    assign w_dy = r_x >>> r_cnt;
    assign w_at = {1'b0, ATAN_TAB[r_cnt[CW-1:0] < CW'(NS) ? r_cnt : '0]};
    assign w_up = r_vec ? !r_y[35] : !r_z[32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_vec  <= i_req.vectoring;
                r_cnt  <= '0;
                r_x    <= i_req.x0;
                r_y    <= i_req.y0;
                r_z    <= i_req.z0;
            end else if (r_busy) begin
                if (r_vec ^ w_up) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                end
                r_z <= w_up ? r_z + (r_vec ? w_at : -w_at) : r_z - (r_vec ? w_at : -w_at);
                if (r_cnt == CW'(NS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;
    assign o_rsp.z    = r_z;
endmodule

// ===== rtl/complementary_yaw_filter.sv =====
//------------------------------------------------------------------------------
// complementary_yaw_filter
// Gyro / quaternion yaw fusion with a shared iterative CORDIC.
//------------------------------------------------------------------------------
// One transaction at a time: a new one is accepted only in idle, after the previous result
// is registered for output; the shared CORDIC runs atan2, then sin/cos. A waiting result
// stalls only the final state.
// The first transaction after reset produces no result.
// Reset is synchronous active low: alpha 64225, yaw 0, waits for a first sample.
module complementary_yaw_filter import cyf_pkg::*; #(
    parameter int ANGLE_BITS   = 18,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cyf_in_if.sink      i_in,
    cyf_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SH = 48 - ANGLE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_VEC, S_VWAIT, S_DT, S_MUL0, S_MUL1, S_GYRO,
        S_BLEND0, S_BLEND1, S_ROT, S_RWAIT, S_OUT
    } t_state;

    t_state              r_state;
    logic [16:0]         r_alpha;
    logic [ANGLE_BITS-1:0] r_yaw;
    logic [47:0]         r_prev, r_t;
    logic                r_first;
    logic signed [17:0]  r_gz;
    logic signed [15:0]  r_qx, r_qy, r_qz, r_qw;
    logic signed [35:0]  r_nx, r_ny;
    logic signed [31:0]  r_meas;
    logic [19:0]         r_dt;
    logic signed [37:0]  r_p;
    logic [63:0]         r_prod;
    logic signed [31:0]  r_gyro;
    logic signed [49:0]  r_sum;
    logic                r_ovalid;
    logic signed [17:0]  r_oyaw;
    logic signed [15:0]  r_oz;
    logic [14:0]         r_ow;
    logic [47:0]         r_otime;
    t_cordic_req         w_req;
    t_cordic_rsp         w_rsp;

    logic [37:0]         w_mag;
    logic signed [31:0]  w_est32;
    logic [16:0]         w_a;
    logic [ANGLE_BITS-1:0] w_ang;
    logic signed [49:0]  w_rnd;
    logic signed [36:0]  w_zr, w_wr;

    assign w_mag   = r_p[37] ? 38'(-r_p) : 38'(r_p);
    assign w_est32 = 32'(signed'(r_yaw)) <<< (32 - ANGLE_BITS);
    assign w_a     = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign w_rnd   = (r_sum + (50'sd1 <<< (SH - 1))) >>> SH;
    assign w_ang   = w_rnd[ANGLE_BITS-1:0];
    assign w_zr    = (37'(signed'(w_rsp.y)) + 37'sd32768) >>> 16;
    assign w_wr    = (37'(signed'(w_rsp.x)) + 37'sd32768) >>> 16;

    always_comb begin
        w_req = '0;
        if (r_state == S_VEC) begin
            w_req.start = 1'b1;
            w_req.vectoring = 1'b1;
            w_req.x0 = r_nx[35] ? -r_nx : r_nx;
            w_req.y0 = r_nx[35] ? -r_ny : r_ny;
            w_req.z0 = r_nx[35] ? 33'sh080000000 : '0;
        end else if (r_state == S_ROT) begin
            w_req.start = 1'b1;
            w_req.x0 = 36'(CORDIC_X0);
            w_req.z0 = 33'(w_est32 >>> 1);
        end
    end

    cyf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ALPHA) ? {15'd0, r_alpha} : 32'd0;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.yaw_angle = r_oyaw;
    assign o_out.out_z = r_oz;
    assign o_out.out_w = r_ow;
    assign o_out.out_time_us = r_otime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_alpha  <= ALPHA_RESET;
            r_yaw    <= '0;
            r_prev   <= '0;
            r_first  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_ALPHA)
                r_alpha <= pwdata[16:0];
            if (r_state == S_OUT && (!r_ovalid || o_out.ready))
                r_ovalid <= 1'b1;
            else if (o_out.valid && o_out.ready)
                r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_t  <= i_in.timestamp_us;
                        r_gz <= i_in.gyro_z;
                        r_qx <= i_in.quat_x;
                        r_qy <= i_in.quat_y;
                        r_qz <= i_in.quat_z;
                        r_qw <= i_in.quat_w;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_ny <= 36'((33'(r_qw * r_qz) + 33'(r_qx * r_qy)) <<< 1);
                    r_nx <= 36'(r_qw * r_qw) + 36'(r_qx * r_qx)
                          - 36'(r_qy * r_qy) - 36'(r_qz * r_qz);
                    r_state <= S_VEC;
                end
                S_VEC: r_state <= S_VWAIT;
                S_VWAIT: begin
                    if (w_rsp.done) begin
                        r_meas <= (r_nx == 0 && r_ny == 0) ? 32'sd0 : w_rsp.z[31:0];
                        r_state <= S_DT;
                    end
                end
                S_DT: begin
                    r_sum <= 50'(r_meas) <<< 16;
                    if (r_first) begin
                        r_state <= S_BLEND1;
                    end else begin
                        if (r_t <= r_prev) r_dt <= DT_FALLBACK;
                        else if (r_t - r_prev > 48'(DT_MAX)) r_dt <= DT_MAX;
                        else r_dt <= 20'(r_t - r_prev);
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_p <= r_gz * signed'({1'b0, r_dt});
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_prod <= 64'(w_mag[31:0]) * 64'(GYRO_MUL) + 64'h80000000;
                    r_gyro <= 32'(w_mag[37:32]) * GYRO_MUL;
                    r_state <= S_GYRO;
                end
                S_GYRO: begin
                    r_gyro <= w_est32 + (r_p[37] ? -(r_gyro + r_prod[63:32])
                                                 : (r_gyro + r_prod[63:32]));
                    r_state <= S_BLEND0;
                end
                S_BLEND0: begin
                    r_sum <= 50'(signed'({1'b0, w_a}) * r_gyro)
                           + 50'(signed'({1'b0, 17'(ALPHA_ONE - w_a)}) * r_meas);
                    r_state <= S_BLEND1;
                end
                S_BLEND1: begin
                    r_yaw  <= w_ang;
                    r_prev <= r_t;
                    if (r_first) begin
                        r_first <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_ROT;
                    end
                end
                S_ROT: r_state <= S_RWAIT;
                S_RWAIT: begin
                    if (w_rsp.done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_oyaw   <= 18'(signed'(r_yaw));
                        r_otime  <= r_t;
                        r_oz <= (w_zr > 37'sd16384) ? 16'sd16384 :
                                (w_zr < -37'sd16384) ? -16'sd16384 : w_zr[15:0];
                        r_ow <= (w_wr > 37'sd16384) ? 15'd16384 :
                                (w_wr < 0) ? 15'd0 : w_wr[14:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_rdy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> r_ovalid) else $error("result dropped");
    a_no_first_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> !r_first) else $error("result on first sample");
`endif
endmodule
